### design/ethrx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethrx_pkg
// Types, codes and the CRC-32 byte step shared by the Ethernet receive parser.
// ----------------------------------------------------------------------------
package ethrx_pkg;

    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0]  PREAMBLE_BYTE  = 8'h55;
    localparam logic [7:0]  SFD_BYTE       = 8'hD5;
    localparam logic [7:0]  STP_BYTE       = 8'h42;
    localparam logic [15:0] ETYPE_VLAN     = 16'h8100;
    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ETYPE_ARP      = 16'h0806;
    localparam logic [15:0] ETYPE_IPV6     = 16'h86DD;
    localparam logic [15:0] ETYPE_LLDP     = 16'h88CC;
    localparam logic [15:0] LLC_LIMIT      = 16'd1500;
    localparam logic [11:0] VLAN_ID_MASK   = 12'hFFF;
    localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
    localparam logic [31:0] CRC_PRESET     = 32'hFFFFFFFF;
    localparam logic [7:0]  PREAMBLE_MAX   = 8'd255;

    localparam logic REG_MODE = 1'b0;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_PRE  = 3'd1,
        PH_DST  = 3'd2,
        PH_SRC  = 3'd3,
        PH_TYPE = 3'd4,
        PH_VLAN = 3'd5,
        PH_PAY  = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        KIND_SFD     = 3'd0,
        KIND_DST_MAC = 3'd1,
        KIND_SRC_MAC = 3'd2,
        KIND_VLAN    = 3'd3,
        KIND_ETYPE   = 3'd4,
        KIND_PAYLOAD = 3'd5,
        KIND_END     = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        CLS_LLC   = 3'd0,
        CLS_STP   = 3'd1,
        CLS_IPV4  = 3'd2,
        CLS_ARP   = 3'd3,
        CLS_VLAN  = 3'd4,
        CLS_IPV6  = 3'd5,
        CLS_LLDP  = 3'd6,
        CLS_OTHER = 3'd7
    } t_class;

    typedef enum logic [1:0] {
        ST_FCS_GOOD  = 2'd0,
        ST_FCS_BAD   = 2'd1,
        ST_UNCHECKED = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [47:0] value;
        t_class      cls;
        t_status     status;
        logic        last;
    } t_result;

    // One byte through the reflected CRC-32, least significant bit first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

    function automatic t_class classify(input logic [15:0] et);
        t_class c;
        if (et < LLC_LIMIT) begin
            c = CLS_LLC;
        end else begin
            unique case (et)
                ETYPE_IPV4: c = CLS_IPV4;
                ETYPE_ARP:  c = CLS_ARP;
                ETYPE_VLAN: c = CLS_VLAN;
                ETYPE_IPV6: c = CLS_IPV6;
                ETYPE_LLDP: c = CLS_LLDP;
                default:    c = CLS_OTHER;
            endcase
        end
        return c;
    endfunction

endpackage

### design/ethernet_rx_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_rx_frame_parser
// Parses received Ethernet bytes into header fields, payload and FCS status.
// ----------------------------------------------------------------------------
// Usage: bytes enter on i_rx_byte / i_end_of_buffer under i_valid; the block
// pushes back with o_stall. Results leave on o_result_kind, o_field_value,
// o_protocol_class, o_frame_status and o_run_last under o_valid, and the
// receiver pushes back with i_stall. A request is taken when valid is high
// and stall is low.
// A byte is caught in an input register and decoded, and its zero, one or
// two results are written into a four-entry result queue that drives the
// outputs. One byte per cycle is sustained while the receiver does not
// stall; the one extra frame-end result per frame is absorbed by the queue
// and the interframe gap. The input stalls only while the queue holds
// more than two results, i.e. when the receiver stalls.
// The APB register at address 0 selects the framing: bit 0 set means
// preamble, SFD and FCS are present. Writing it restarts the parser. The user
// writes it only while no request is in flight; the block does not enforce it.
// Reset (i_rst_n low, synchronous) empties the queue, sets the register to
// 1 and puts the parser in preamble hunt.
// ----------------------------------------------------------------------------
module ethernet_rx_frame_parser
    import ethrx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_buffer,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_result_kind,
    output logic [47:0] o_field_value,
    output logic [2:0]  o_protocol_class,
    output logic [1:0]  o_frame_status,
    output logic        o_run_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Configuration and input register.
    logic        r_mode;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eob;

    // Parser state.
    t_phase      r_phase,   n_phase;
    logic [2:0]  r_cnt,     n_cnt;
    logic [47:0] r_shift,   n_shift;
    logic [7:0]  r_pre,     n_pre;
    logic [31:0] r_hold,    n_hold;
    logic [2:0]  r_fill,    n_fill;
    logic [31:0] r_crc,     n_crc;
    t_class      r_cls,     n_cls;
    logic        r_llc,     n_llc;

    // Result queue.
    t_result                r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     r_wr_ptr;
    logic [FIFO_AW-1:0]     r_rd_ptr;
    logic [FIFO_AW:0]       r_count;

    logic       cfg_wr;
    logic       proc;
    logic       pop;
    logic [1:0] n_push;
    t_result    res0, res1;

    assign pready = 1'b1;
    assign prdata = {31'd0, r_mode};
    assign cfg_wr = psel && penable && pwrite && pready;

    assign proc    = r_in_valid && (r_count <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
    assign o_stall = r_in_valid && !proc;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;

    assign o_result_kind    = r_fifo[r_rd_ptr].kind;
    assign o_field_value    = r_fifo[r_rd_ptr].value;
    assign o_protocol_class = r_fifo[r_rd_ptr].cls;
    assign o_frame_status   = r_fifo[r_rd_ptr].status;
    assign o_run_last       = r_fifo[r_rd_ptr].last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall) begin
            r_in_byte <= i_rx_byte;
            r_in_eob  <= i_end_of_buffer;
        end
    end

    // Next-state decode of the registered byte.
    always_comb begin
        logic        body;
        logic        open;
        logic [15:0] v;
        logic [31:0] rx_fcs;
        t_status     st;
        logic [47:0] end_val;

        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_pre   = r_pre;
        n_hold  = r_hold;
        n_fill  = r_fill;
        n_crc   = r_crc;
        n_cls   = r_cls;
        n_llc   = r_llc;
        res0    = '0;
        res1    = '0;
        body    = 1'b0;
        open    = 1'b1;
        v       = 16'd0;
        rx_fcs  = 32'd0;
        st      = ST_TRUNCATED;
        end_val = 48'd0;

        if (r_llc) begin
            if (r_in_byte == STP_BYTE) begin
                n_cls = CLS_STP;
            end
            n_llc = 1'b0;
        end

        unique case (r_phase)
            PH_IDLE: begin
                if (r_in_byte == PREAMBLE_BYTE) begin
                    n_phase = PH_PRE;
                    n_pre   = 8'd1;
                end else begin
                    open = 1'b0;
                end
            end
            PH_PRE: begin
                if (r_in_byte == SFD_BYTE) begin
                    res0    = '{KIND_SFD, {40'd0, r_pre}, CLS_LLC, ST_FCS_GOOD, 1'b0};
                    body    = 1'b1;
                    n_phase = PH_DST;
                    n_cnt   = 3'd0;
                    n_shift = 48'd0;
                    n_crc   = CRC_PRESET;
                end else if (r_in_byte == PREAMBLE_BYTE && r_pre < PREAMBLE_MAX) begin
                    n_pre = r_pre + 8'd1;
                end
            end
            PH_DST, PH_SRC: begin
                n_crc   = crc32_byte(r_crc, r_in_byte);
                n_shift = {r_shift[39:0], r_in_byte};
                n_cnt   = r_cnt + 3'd1;
                if (n_cnt >= 3'd6) begin
                    res0    = '{(r_phase == PH_DST) ? KIND_DST_MAC : KIND_SRC_MAC,
                                n_shift, CLS_LLC, ST_FCS_GOOD, 1'b0};
                    body    = 1'b1;
                    n_phase = (r_phase == PH_DST) ? PH_SRC : PH_TYPE;
                    n_cnt   = 3'd0;
                    n_shift = 48'd0;
                end
            end
            PH_TYPE, PH_VLAN: begin
                n_crc   = crc32_byte(r_crc, r_in_byte);
                n_shift = {r_shift[39:0], r_in_byte};
                n_cnt   = r_cnt + 3'd1;
                if (n_cnt >= 3'd2) begin
                    v    = n_shift[15:0];
                    body = 1'b1;
                    if (r_phase == PH_VLAN) begin
                        res0    = '{KIND_VLAN, {36'd0, v[11:0] & VLAN_ID_MASK},
                                    CLS_LLC, ST_FCS_GOOD, 1'b0};
                        n_phase = PH_TYPE;
                    end else begin
                        res0    = '{KIND_ETYPE, {32'd0, v}, CLS_LLC, ST_FCS_GOOD, 1'b0};
                        n_cls   = classify(v);
                        n_llc   = (v < LLC_LIMIT);
                        n_phase = (v == ETYPE_VLAN) ? PH_VLAN : PH_PAY;
                    end
                    n_cnt   = 3'd0;
                    n_shift = 48'd0;
                end
            end
            PH_PAY: begin
                if (r_mode) begin
                    if (r_fill >= 3'd4) begin
                        n_crc = crc32_byte(r_crc, r_hold[31:24]);
                        res0  = '{KIND_PAYLOAD, {40'd0, r_hold[31:24]},
                                  CLS_LLC, ST_FCS_GOOD, 1'b0};
                        body  = 1'b1;
                    end else begin
                        n_fill = r_fill + 3'd1;
                    end
                    n_hold = {r_hold[23:0], r_in_byte};
                end else begin
                    n_crc = crc32_byte(r_crc, r_in_byte);
                    res0  = '{KIND_PAYLOAD, {40'd0, r_in_byte}, CLS_LLC, ST_FCS_GOOD, 1'b0};
                    body  = 1'b1;
                end
            end
            default: begin
                open = 1'b0;
                n_phase = r_mode ? PH_IDLE : PH_DST;
                n_cnt   = 3'd0;
                n_shift = 48'd0;
                n_pre   = 8'd0;
                n_hold  = 32'd0;
                n_fill  = 3'd0;
                n_crc   = CRC_PRESET;
                n_cls   = CLS_LLC;
                n_llc   = 1'b0;
            end
        endcase

        if (r_in_eob && open) begin
            if (r_phase == PH_PAY) begin
                if (!r_mode) begin
                    st = ST_UNCHECKED;
                end else if (n_fill >= 3'd4) begin
                    // The FCS is sent least significant byte first.
                    rx_fcs  = {n_hold[7:0], n_hold[15:8], n_hold[23:16], n_hold[31:24]};
                    st      = (rx_fcs == ~n_crc) ? ST_FCS_GOOD : ST_FCS_BAD;
                    end_val = {16'd0, n_hold};
                end
            end
            if (body) begin
                res1 = '{KIND_END, end_val, n_cls, st, 1'b1};
            end else begin
                res0 = '{KIND_END, end_val, n_cls, st, 1'b1};
            end
            n_phase = r_mode ? PH_IDLE : PH_DST;
            n_cnt   = 3'd0;
            n_shift = 48'd0;
            n_pre   = 8'd0;
            n_hold  = 32'd0;
            n_fill  = 3'd0;
            n_crc   = CRC_PRESET;
            n_cls   = CLS_LLC;
            n_llc   = 1'b0;
        end else if (body) begin
            res0.last = 1'b1;
        end

        n_push = {1'b0, body} + {1'b0, r_in_eob && open};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b1;
            r_phase <= PH_IDLE;
            r_cnt   <= 3'd0;
            r_shift <= 48'd0;
            r_pre   <= 8'd0;
            r_hold  <= 32'd0;
            r_fill  <= 3'd0;
            r_crc   <= CRC_PRESET;
            r_cls   <= CLS_LLC;
            r_llc   <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MODE) begin
                r_mode  <= pwdata[0];
                r_phase <= pwdata[0] ? PH_IDLE : PH_DST;
                r_cnt   <= 3'd0;
                r_shift <= 48'd0;
                r_pre   <= 8'd0;
                r_hold  <= 32'd0;
                r_fill  <= 3'd0;
                r_crc   <= CRC_PRESET;
                r_cls   <= CLS_LLC;
                r_llc   <= 1'b0;
            end
        end else if (proc) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_pre   <= n_pre;
            r_hold  <= n_hold;
            r_fill  <= n_fill;
            r_crc   <= n_crc;
            r_cls   <= n_cls;
            r_llc   <= n_llc;
        end
    end

    // Result queue: up to two writes per decoded byte, one read per cycle.
    always_ff @(posedge i_clk) begin
        if (proc && n_push != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (proc && n_push == 2'd2) begin
            r_fifo[r_wr_ptr + FIFO_AW'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (proc) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(n_push);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + (proc ? (FIFO_AW + 1)'(n_push) : '0)
                               - (FIFO_AW + 1)'(pop);
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (FIFO_AW + 1)'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_hold_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 3'd4)
        else $error("FCS hold fill out of range");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == KIND_END) |-> o_run_last)
        else $error("frame end result not marked last");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind != KIND_END) |->
            (o_protocol_class == CLS_LLC && o_frame_status == ST_FCS_GOOD))
        else $error("class or status on a non-end result");

    a_restart_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && !cfg_wr && r_in_eob && r_phase != PH_IDLE) |=>
            (r_phase == (r_mode ? PH_IDLE : PH_DST) && r_fill == 3'd0))
        else $error("parser did not restart after frame end");
`endif

endmodule

### test/ethernet_rx_frame_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_rx_frame_parser_tb
// Self-checking bench for the Ethernet receive frame parser.
// ----------------------------------------------------------------------------
// Received bytes are built into whole or cut-short frames, with and without
// preamble and FCS, plus some line noise. A byte-level model of the parser
// runs on every accepted request and queues the results it should produce.
// The monitor compares each accepted result field by field with the oldest
// queued one. The framing mode is changed over the APB port between phases,
// and each pair of phases uses its own mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module ethernet_rx_frame_parser_tb;
    import ethrx_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       eob;
    } t_rx_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        i_end_of_buffer = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_result_kind;
    logic [47:0] o_field_value;
    logic [2:0]  o_protocol_class;
    logic [1:0]  o_frame_status;
    logic        o_run_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    ethernet_rx_frame_parser u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .i_end_of_buffer  (i_end_of_buffer),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_kind    (o_result_kind),
        .o_field_value    (o_field_value),
        .o_protocol_class (o_protocol_class),
        .o_frame_status   (o_frame_status),
        .o_run_last       (o_run_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_rx_item    rx_items[$];
    t_result     expected_results[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned fail_count = 0;
    int unsigned bytes_queued = 0;
    int unsigned bytes_sent = 0;
    int unsigned results_checked = 0;
    int unsigned frame_ends_seen = 0;

    // Parser state as the bench sees it.
    logic        mode_fcs;
    t_phase      rx_phase;
    int unsigned hdr_bytes;
    logic [47:0] hdr_shift;
    logic [7:0]  pre_cnt;
    logic [31:0] fcs_window;
    int unsigned window_fill;
    logic [31:0] crc_acc;
    t_class      frame_class;
    logic        stp_probe;

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c ^ {24'd0, d};
        for (int k = 0; k < 8; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic t_class frame_class_of(input logic [15:0] etype);
        if (etype < LLC_LIMIT) return CLS_LLC;
        if (etype == ETYPE_IPV4) return CLS_IPV4;
        if (etype == ETYPE_ARP) return CLS_ARP;
        if (etype == ETYPE_VLAN) return CLS_VLAN;
        if (etype == ETYPE_IPV6) return CLS_IPV6;
        if (etype == ETYPE_LLDP) return CLS_LLDP;
        return CLS_OTHER;
    endfunction

    task automatic restart_parser();
        if (mode_fcs) begin
            rx_phase = PH_IDLE;
        end else begin
            rx_phase = PH_DST;
        end
        hdr_bytes   = 0;
        hdr_shift   = '0;
        pre_cnt     = '0;
        fcs_window  = '0;
        window_fill = 0;
        crc_acc     = CRC_PRESET;
        frame_class = CLS_LLC;
        stp_probe   = 1'b0;
    endtask

    task automatic post_result(input t_kind kind, input logic [47:0] value,
                               input t_class cls, input t_status st);
        t_result r;
        r.kind   = kind;
        r.value  = value;
        r.cls    = cls;
        r.status = st;
        r.last   = 1'b0;
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic take_header_byte(input logic [7:0] b);
        crc_acc   = crc_step(crc_acc, b);
        hdr_shift = {hdr_shift[39:0], b};
        hdr_bytes++;
    endtask

    // Works out the results that one accepted byte should produce.
    task automatic predict_byte(input logic [7:0] b, input logic eob);
        t_phase      entry;
        logic        opened;
        int unsigned base;
        logic [15:0] tag;
        logic [7:0]  oldest;
        logic [31:0] fcs_rx;
        t_status     st;
        logic [47:0] val;
        t_result     r;
        entry  = rx_phase;
        opened = 1'b1;
        base   = expected_results.size();

        // The byte after an LLC length decides between LLC and STP.
        if (stp_probe) begin
            if (b == STP_BYTE) frame_class = CLS_STP;
            stp_probe = 1'b0;
        end

        case (rx_phase)
            PH_IDLE: begin
                if (b == PREAMBLE_BYTE) begin
                    rx_phase = PH_PRE;
                    pre_cnt  = 8'd1;
                end else begin
                    opened = 1'b0;
                end
            end
            PH_PRE: begin
                if (b == SFD_BYTE) begin
                    post_result(KIND_SFD, {40'd0, pre_cnt}, CLS_LLC, ST_FCS_GOOD);
                    rx_phase  = PH_DST;
                    hdr_bytes = 0;
                    hdr_shift = '0;
                    crc_acc   = CRC_PRESET;
                end else if (b == PREAMBLE_BYTE && pre_cnt != PREAMBLE_MAX) begin
                    pre_cnt = pre_cnt + 8'd1;
                end
            end
            PH_DST, PH_SRC: begin
                take_header_byte(b);
                if (hdr_bytes == 6) begin
                    if (rx_phase == PH_DST) begin
                        post_result(KIND_DST_MAC, hdr_shift, CLS_LLC, ST_FCS_GOOD);
                        rx_phase = PH_SRC;
                    end else begin
                        post_result(KIND_SRC_MAC, hdr_shift, CLS_LLC, ST_FCS_GOOD);
                        rx_phase = PH_TYPE;
                    end
                    hdr_bytes = 0;
                    hdr_shift = '0;
                end
            end
            PH_TYPE, PH_VLAN: begin
                take_header_byte(b);
                if (hdr_bytes == 2) begin
                    tag = hdr_shift[15:0];
                    if (rx_phase == PH_VLAN) begin
                        post_result(KIND_VLAN, {36'd0, tag[11:0]}, CLS_LLC, ST_FCS_GOOD);
                        rx_phase = PH_TYPE;
                    end else begin
                        post_result(KIND_ETYPE, {32'd0, tag}, CLS_LLC, ST_FCS_GOOD);
                        frame_class = frame_class_of(tag);
                        stp_probe   = (tag < LLC_LIMIT);
                        if (tag == ETYPE_VLAN) begin
                            rx_phase = PH_VLAN;
                        end else begin
                            rx_phase = PH_PAY;
                        end
                    end
                    hdr_bytes = 0;
                    hdr_shift = '0;
                end
            end
            PH_PAY: begin
                if (mode_fcs) begin
                    // The last four bytes stay in the window as the FCS.
                    if (window_fill == 4) begin
                        oldest  = fcs_window[31:24];
                        crc_acc = crc_step(crc_acc, oldest);
                        post_result(KIND_PAYLOAD, {40'd0, oldest}, CLS_LLC, ST_FCS_GOOD);
                    end else begin
                        window_fill++;
                    end
                    fcs_window = {fcs_window[23:0], b};
                end else begin
                    crc_acc = crc_step(crc_acc, b);
                    post_result(KIND_PAYLOAD, {40'd0, b}, CLS_LLC, ST_FCS_GOOD);
                end
            end
            default: begin
                restart_parser();
                opened = 1'b0;
            end
        endcase

        if (eob && opened) begin
            st  = ST_TRUNCATED;
            val = '0;
            if (entry == PH_PAY) begin
                if (!mode_fcs) begin
                    st = ST_UNCHECKED;
                end else if (window_fill == 4) begin
                    // The FCS travels least significant byte first.
                    fcs_rx = {fcs_window[7:0], fcs_window[15:8],
                              fcs_window[23:16], fcs_window[31:24]};
                    st  = (fcs_rx == ~crc_acc) ? ST_FCS_GOOD : ST_FCS_BAD;
                    val = {16'd0, fcs_window};
                end
            end
            post_result(KIND_END, val, frame_class, st);
            restart_parser();
        end

        if (expected_results.size() > base) begin
            r = expected_results.pop_back();
            r.last = 1'b1;
            expected_results.insert(expected_results.size(), r);
        end
    endtask

    always @(posedge i_clk) begin
        t_rx_item next;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_byte(i_rx_byte, i_end_of_buffer);
                bytes_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (rx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next = rx_items.pop_front();
                    i_valid         <= 1'b1;
                    i_rx_byte       <= next.data;
                    i_end_of_buffer <= next.eob;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [47:0] want,
                               input logic [47:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("Unexpected result: kind %0d, value 0x%0h",
                           o_result_kind, o_field_value);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("result_kind", 48'(want.kind), 48'(o_result_kind));
                    check_field("field_value", want.value, o_field_value);
                    check_field("protocol_class", 48'(want.cls), 48'(o_protocol_class));
                    check_field("frame_status", 48'(want.status), 48'(o_frame_status));
                    check_field("run_last", 48'(want.last), 48'(o_run_last));
                    results_checked++;
                    if (want.kind == KIND_END) frame_ends_seen++;
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic eob);
        t_rx_item item;
        item.data = data;
        item.eob  = eob;
        rx_items.insert(rx_items.size(), item);
        bytes_queued++;
    endtask

    task automatic queue_frame(input logic with_fcs, input int unsigned pre_len);
        logic [7:0]  frame[$];
        logic [31:0] crc;
        logic [31:0] fcs;
        logic [15:0] etype;
        logic [7:0]  junk;
        int unsigned body_start;
        int unsigned n_tags;
        int unsigned pay_len;
        int unsigned cut;
        logic        mac_ones;
        if (with_fcs) begin
            repeat ($urandom_range(2)) frame.insert(frame.size(), 8'($urandom_range(255)));
            repeat (pre_len) frame.insert(frame.size(), PREAMBLE_BYTE);
            if ($urandom_range(9) == 0) begin
                junk = 8'($urandom_range(255));
                if (junk == SFD_BYTE) junk = 8'h00;
                frame.insert(frame.size(), junk);
            end
            frame.insert(frame.size(), SFD_BYTE);
        end
        body_start = frame.size();

        for (int m = 0; m < 2; m++) begin
            mac_ones = ($urandom_range(7) == 0);
            for (int k = 0; k < 6; k++) begin
                frame.insert(frame.size(), mac_ones ? 8'hFF : 8'($urandom_range(255)));
            end
        end

        n_tags = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n_tags) begin
            frame.insert(frame.size(), ETYPE_VLAN[15:8]);
            frame.insert(frame.size(), ETYPE_VLAN[7:0]);
            frame.insert(frame.size(), 8'($urandom_range(255)));
            frame.insert(frame.size(), 8'($urandom_range(255)));
        end

        case ($urandom_range(11))
            0:       etype = 16'($urandom_range(1499));
            1:       etype = LLC_LIMIT - 16'd1;
            2:       etype = LLC_LIMIT;
            3:       etype = ETYPE_IPV4;
            4:       etype = ETYPE_ARP;
            5:       etype = ETYPE_IPV6;
            6:       etype = ETYPE_LLDP;
            7:       etype = 16'hFFFF;
            8:       etype = 16'h0000;
            default: etype = 16'($urandom_range(16'hFFFF));
        endcase
        frame.insert(frame.size(), etype[15:8]);
        frame.insert(frame.size(), etype[7:0]);

        pay_len = ($urandom_range(7) == 0) ? $urandom_range(13, 40) : $urandom_range(12);
        for (int k = 0; k < pay_len; k++) begin
            if (k == 0 && $urandom_range(1) == 0) begin
                frame.insert(frame.size(), STP_BYTE);
            end else begin
                frame.insert(frame.size(), 8'($urandom_range(255)));
            end
        end

        if (with_fcs) begin
            crc = CRC_PRESET;
            for (int k = body_start; k < frame.size(); k++) crc = crc_step(crc, frame[k]);
            fcs = ~crc;
            if ($urandom_range(4) == 0) fcs = fcs ^ (32'd1 << $urandom_range(31));
            for (int k = 0; k < 4; k++) frame.insert(frame.size(), fcs[8*k +: 8]);
        end

        // Some frames are cut short anywhere, header or payload.
        cut = frame.size() - 1;
        if ($urandom_range(5) == 0) cut = $urandom_range(frame.size() - 1);
        for (int k = 0; k <= cut; k++) push_byte(frame[k], k == cut);
    endtask

    task automatic queue_noise();
        int unsigned n;
        logic [7:0]  b;
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(3))
                0:       b = PREAMBLE_BYTE;
                1:       b = SFD_BYTE;
                default: b = 8'($urandom_range(255));
            endcase
            push_byte(b, (k == n - 1) || ($urandom_range(15) == 0));
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (rx_items.size() != 0 || i_valid || expected_results.size() != 0);
        // A trailing byte may cause no result and still be in the pipeline.
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apb_write_mode(input logic value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MODE, 2'b00};
        pwdata  <= {31'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mode_fcs = value;
        restart_parser();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        int unsigned target;
        int unsigned mix;
        logic        fcs_on;
        mode_fcs = 1'b1;
        restart_parser();
        do @(posedge i_clk);
        while (!i_rst_n);
        @(negedge i_clk);

        // Final byte while hunting: no result for garbage, truncated for 0x55.
        push_byte(8'h00, 1'b1);
        push_byte(PREAMBLE_BYTE, 1'b1);
        // Garbage inside the preamble, frame ending on the SFD.
        push_byte(PREAMBLE_BYTE, 1'b0);
        push_byte(8'h3C, 1'b0);
        push_byte(PREAMBLE_BYTE, 1'b0);
        push_byte(SFD_BYTE, 1'b1);
        // All-ones destination, frame cut inside the source MAC.
        push_byte(PREAMBLE_BYTE, 1'b0);
        push_byte(SFD_BYTE, 1'b0);
        repeat (6) push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h00, 1'b1);

        for (int p = 0; p < 8; p++) begin
            fcs_on = (p % 2 == 0);
            mix    = p / 2;
            if (p != 0) begin
                wait_drained();
                apb_write_mode(fcs_on);
                @(negedge i_clk);
            end
            send_idle_pct  = (mix == 1) ? 51 : (mix == 3) ? 6 : 0;
            recv_stall_pct = (mix == 2) ? 51 : (mix == 3) ? 6 : 0;
            // One very long preamble drives the count into saturation.
            if (p == 0) queue_frame(1'b1, 260);
            target = bytes_queued + 20;
            while (bytes_queued < target) begin
                if ($urandom_range(9) == 0) begin
                    queue_noise();
                end else begin
                    queue_frame(fcs_on, $urandom_range(1, 8));
                end
            end
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            fail_count++;
        end
        $display("Sent %0d bytes in eight phases, both framing modes, four gap/stall mixes.",
                 bytes_sent);
        $display("Checked %0d results, %0d of them frame ends.",
                 results_checked, frame_ends_seen);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
design/ethrx_pkg.sv
design/ethernet_rx_frame_parser.sv
test/ethernet_rx_frame_parser_tb.sv
